### sv/limit_order_book_assert.svh
// Assertion macros for the order book
`ifndef LIMIT_ORDER_BOOK_ASSERT_SVH
`define LIMIT_ORDER_BOOK_ASSERT_SVH
`ifndef SYNTHESIS
`define LOB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define LOB_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LOB_ASSERT(label, clk, rst, prop)
`define LOB_ASSERT_RST(label, clk, prop)
`endif
`endif

### sv/lob_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lob_pkg
// Shared codes and types for the order book.
// ---------------------------------------------------------------------------
package lob_pkg;
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_BUY    = 2'd2,
    ACT_SELL   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUP       = 3'd4
  } status_t;

  localparam int SLOT_W = 65;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic        side;
  } slot_t;
endpackage

### sv/lob_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lob_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module lob_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/limit_order_book.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// limit_order_book
// Bounded price-time priority order book over one slot RAM.
// ---------------------------------------------------------------------------
// Input channel (valid/ready): action, order_id, side, price. Output channel
// (valid/ready): status, out_id, out_side, out_price, last; a query gives one
// transaction per order at the best price, last on the final one, others give
// a single transaction.
// One command at a time. Every pass walks the slot RAM one entry per cycle
// (emit only while results are taken), through the registered read port:
//   add:    id scan, then the write
//   remove: id scan, then a shift-down pass
//   query:  best-price scan, last-match scan, emit scan
// Resting orders number at most BOOK_SLOTS. The emit
// pass waits on out_ready; a stalled receiver holds the scan in place.
// Reset clears the order count; the RAM needs no clearing pass since only
// slots below the count are read. ready is low while a command is in work.
// ---------------------------------------------------------------------------
module limit_order_book #(
  parameter int BOOK_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] order_id,
  input  logic        side,
  input  logic [31:0] price,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] out_id,
  output logic        out_side,
  output logic [31:0] out_price,
  output logic        last
);
  import lob_pkg::*;
  `include "limit_order_book_assert.svh"

  localparam int AW = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
  localparam int CW = $clog2(BOOK_SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_BEST  = 7'b0001000,
    S_LASTP = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [1:0]     act;
  logic [31:0]    key_id;
  logic [31:0]    key_price;
  logic           key_side;
  logic [CW-1:0]  rptr;      // address issued this cycle
  logic           rvld;      // rdata valid for slot rptr_d
  logic [CW-1:0]  rptr_d;
  logic           found;
  logic [31:0]    best;
  logic [CW-1:0]  lastpos;
  logic [CW-1:0]  wptr;

  logic           we;
  logic [AW-1:0]  waddr;
  slot_t          wdata;
  logic [AW-1:0]  raddr;
  slot_t          rdata;
  logic [SLOT_W-1:0] rdata_raw;

  lob_ram #(.WIDTH(SLOT_W), .DEPTH(BOOK_SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = slot_t'(rdata_raw);

  logic want;
  logic match;
  logic better;
  assign want   = (act == ACT_SELL);
  assign match  = rvld && (rdata.side == want) && (!found || rdata.price == best);
  assign better = want ? (rdata.price < best) : (rdata.price > best);

  // output register
  logic stall;
  assign stall = out_valid && !out_ready;

  assign in_ready = (state == S_IDLE);
  // a stalled emit re-reads the held slot
  assign raddr    = (state == S_EMIT && stall) ? rptr_d[AW-1:0] : rptr[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = wptr[AW-1:0];
    wdata = rdata;
    if (state == S_SHIFT && rvld) begin
      we    = 1'b1;
      waddr = AW'(rptr_d - CW'(1));
    end else if (state == S_OUT && act == ACT_ADD && !found && count < CW'(BOOK_SLOTS)
                 && !out_valid) begin
      we    = 1'b1;
      waddr = count[AW-1:0];
      wdata = '{id: key_id, price: key_price, side: key_side};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rvld      <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act       <= action;
            key_id    <= order_id;
            key_side  <= side;
            key_price <= price;
            found     <= 1'b0;
            rptr      <= '0;
            rvld      <= 1'b0;
            state     <= (action == ACT_ADD || action == ACT_REMOVE) ? S_FIND : S_BEST;
          end
        end
        S_FIND: begin
          // address rptr issued now; data of rptr_d available
          if (rvld && rdata.id == key_id) begin
            found <= 1'b1;
            wptr  <= rptr_d;
            rvld  <= 1'b0;
            if (act == ACT_REMOVE) begin
              rptr  <= rptr_d + CW'(1);
              state <= S_SHIFT;
            end else begin
              state <= S_OUT;
            end
          end else if (rptr >= count) begin
            rvld  <= 1'b0;
            state <= S_OUT;
          end else begin
            rvld   <= 1'b1;
            rptr_d <= rptr;
            rptr   <= rptr + CW'(1);
          end
        end
        S_SHIFT: begin
          if (rptr >= count) begin
            if (!rvld) begin
              count <= count - CW'(1);
              state <= S_OUT;
            end
            rvld <= 1'b0;
          end else begin
            rvld   <= 1'b1;
            rptr_d <= rptr;
            rptr   <= rptr + CW'(1);
          end
        end
        S_BEST: begin
          if (rvld && rdata.side == want && (!found || better)) begin
            best  <= rdata.price;
            found <= 1'b1;
          end
          if (rptr >= count) begin
            rvld <= 1'b0;
            if (!rvld) begin
              rptr  <= '0;
              state <= found ? S_LASTP : S_OUT;
            end
          end else begin
            rvld   <= 1'b1;
            rptr_d <= rptr;
            rptr   <= rptr + CW'(1);
          end
        end
        S_LASTP: begin
          if (match) lastpos <= rptr_d;
          if (rptr >= count) begin
            rvld <= 1'b0;
            if (!rvld) begin
              rptr  <= '0;
              state <= S_EMIT;
            end
          end else begin
            rvld   <= 1'b1;
            rptr_d <= rptr;
            rptr   <= rptr + CW'(1);
          end
        end
        S_EMIT: begin
          if (!stall) begin
            if (match) begin
              out_valid <= 1'b1;
              status    <= ST_OK;
              out_id    <= rdata.id;
              out_side  <= rdata.side;
              out_price <= rdata.price;
              last      <= (rptr_d == lastpos);
            end
            if (match && rptr_d == lastpos) begin
              rvld  <= 1'b0;
              state <= S_IDLE;
            end else begin
              rvld   <= 1'b1;
              rptr_d <= rptr;
              rptr   <= rptr + CW'(1);
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_id    <= '0;
            out_side  <= 1'b0;
            out_price <= '0;
            last      <= 1'b1;
            state     <= S_IDLE;
            case (act)
              ACT_ADD: begin
                if (found) status <= ST_DUP;
                else if (count >= CW'(BOOK_SLOTS)) status <= ST_FULL;
                else begin
                  status <= ST_OK;
                  count  <= count + CW'(1);
                end
              end
              ACT_REMOVE: status <= found ? ST_OK : ST_NOT_FOUND;
              default: status <= ST_EMPTY;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LOB_ASSERT(a_count_range, clk, rst, count <= CW'(BOOK_SLOTS))
  `LOB_ASSERT(a_busy_no_ready, clk, rst, (state != S_IDLE) |-> !in_ready)
  `LOB_ASSERT(a_add_grows, clk, rst,
    (state == S_OUT && act == ACT_ADD && !found && count < CW'(BOOK_SLOTS) && !out_valid)
    |=> (count == $past(count) + CW'(1)))
  `LOB_ASSERT(a_hold_out, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_id) && $stable(last)))
endmodule

### dv/lob_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lob_checker
// Order book predictor and result checker.
// ---------------------------------------------------------------------------
// Watches both channels. Each accepted command is applied to a local copy of
// the book and the results it should give are queued; each output
// transaction is compared field by field with the oldest queued result.
// ---------------------------------------------------------------------------
module lob_checker #(
  parameter int BOOK_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] order_id,
  input  logic        side,
  input  logic [31:0] price,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [31:0] out_id,
  input  logic        out_side,
  input  logic [31:0] out_price,
  input  logic        last,
  output int          errors,
  output int          pending,
  output int          n_results
);
  import lob_pkg::*;

  typedef struct {
    status_t     st;
    logic [31:0] id;
    logic        sd;
    logic [31:0] pr;
    logic        lst;
  } book_result_t;

  slot_t        book[$];
  book_result_t due_results[$];

  initial begin
    errors = 0;
    pending = 0;
    n_results = 0;
  end

  function automatic void expect_result(book_result_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic int locate_order(logic [31:0] id);
    foreach (book[i]) if (book[i].id == id) return i;
    return -1;
  endfunction

  function automatic book_result_t plain_result(status_t st);
    book_result_t r;
    r.st = st; r.id = '0; r.sd = 1'b0; r.pr = '0; r.lst = 1'b1;
    return r;
  endfunction

  task automatic apply_command(action_t act, logic [31:0] id, logic sd,
                               logic [31:0] pr);
    slot_t        s;
    book_result_t r;
    logic [31:0]  best;
    logic         want, found;
    int           lastpos, pos;
    best = '0; found = 1'b0; lastpos = 0;
    case (act)
      ACT_ADD: begin
        if (locate_order(id) >= 0) expect_result(plain_result(ST_DUP));
        else if (book.size() >= BOOK_SLOTS)
          expect_result(plain_result(ST_FULL));
        else begin
          s.id = id; s.price = pr; s.side = sd;
          book.insert(book.size(), s);
          expect_result(plain_result(ST_OK));
        end
      end
      ACT_REMOVE: begin
        pos = locate_order(id);
        if (pos < 0) expect_result(plain_result(ST_NOT_FOUND));
        else begin
          book.delete(pos);
          expect_result(plain_result(ST_OK));
        end
      end
      default: begin
        want = (act == ACT_SELL);
        foreach (book[i]) if (book[i].side == want) begin
          if (!found || (want ? book[i].price < best : book[i].price > best))
            best = book[i].price;
          found = 1'b1;
        end
        if (!found) expect_result(plain_result(ST_EMPTY));
        else begin
          foreach (book[i])
            if (book[i].side == want && book[i].price == best) lastpos = i;
          foreach (book[i]) if (book[i].side == want && book[i].price == best) begin
            r.st = ST_OK; r.id = book[i].id; r.sd = want; r.pr = best;
            r.lst = (i == lastpos);
            expect_result(r);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    book_result_t e;
    int           bad;
    bad = 0;
    if (rst) begin
      book.delete();
      due_results.delete();
    end else begin
      if (in_valid && in_ready)
        apply_command(action_t'(action), order_id, side, price);
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (due_results.size() == 0) begin
          $error("unexpected result transaction");
          bad++;
        end else begin
          e = due_results.pop_front();
          if (status !== e.st) begin
            $error("status: expected %0d actual %0d", e.st, status);
            bad++;
          end
          if (out_id !== e.id) begin
            $error("out_id: expected %0h actual %0h", e.id, out_id);
            bad++;
          end
          if (out_side !== e.sd) begin
            $error("out_side: expected %0d actual %0d", e.sd, out_side);
            bad++;
          end
          if (out_price !== e.pr) begin
            $error("out_price: expected %0h actual %0h", e.pr, out_price);
            bad++;
          end
          if (last !== e.lst) begin
            $error("last: expected %0d actual %0d", e.lst, last);
            bad++;
          end
        end
      end
    end
    errors  <= errors + bad;
    pending <= due_results.size();
  end
endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the order book.
// ---------------------------------------------------------------------------
// Directed adds, removes and queries cover empty sides, duplicate ids, a full
// book, unknown ids and extreme prices; then random order flow over a small
// id pool with bursty input and a stalling receiver. Checking is in
// lob_checker.
// ---------------------------------------------------------------------------
module testbench;
  import lob_pkg::*;

  localparam int SLOTS = 64;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [1:0]  action;
  logic [31:0] order_id, price;
  logic        side;
  logic        out_valid, out_ready;
  logic [2:0]  status;
  logic [31:0] out_id, out_price;
  logic        out_side, last;
  int          errors, pending, n_results;
  int          n_sent;
  bit          stall_mode;

  limit_order_book #(.BOOK_SLOTS(SLOTS)) dut (.*);

  lob_checker #(.BOOK_SLOTS(SLOTS)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("limit_order_book test failed");
    $finish;
  end

  // receiver stall pattern: alternating free and choppy stretches
  initial begin
    out_ready = 1'b0;
    stall_mode = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 40) == 0) stall_mode = ~stall_mode;
      out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  task automatic send_command(action_t act, logic [31:0] id, logic sd,
                              logic [31:0] pr);
    in_valid <= 1'b1;
    action   <= act;
    order_id <= id;
    side     <= sd;
    price    <= pr;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic drain_book();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    logic [31:0] id, pr;
    int          k;
    in_valid = 1'b0;
    action = ACT_ADD;
    order_id = '0;
    side = 1'b0;
    price = '0;
    n_sent = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(ACT_BUY, 32'h0, 1'b1, 32'hFFFF_FFFF);
    send_command(ACT_SELL, 32'hFFFF_FFFF, 1'b0, 32'h0);
    send_command(ACT_REMOVE, 32'h1234, 1'b0, 32'h0);
    send_command(ACT_ADD, 32'h0, 1'b0, 32'h0);
    send_command(ACT_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_command(ACT_ADD, 32'h0, 1'b1, 32'h5);
    send_command(ACT_ADD, 32'h5555_AAAA, 1'b0, 32'h0);
    send_command(ACT_ADD, 32'hAAAA_5555, 1'b1, 32'hFFFF_FFFF);
    send_command(ACT_ADD, 32'h7, 1'b0, 32'hFFFF_FFFE);
    send_command(ACT_BUY, 32'h0, 1'b0, 32'h0);
    send_command(ACT_SELL, 32'h0, 1'b0, 32'h0);
    send_command(ACT_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_command(ACT_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'h0);
    send_command(ACT_SELL, 32'h0, 1'b0, 32'h0);
    drain_book();

    // fill to capacity, overflow, then query a long run of equal prices
    for (k = 5; k < SLOTS + 2; k++)
      send_command(ACT_ADD, 32'h100 + k, k[0], 32'h40);
    send_command(ACT_BUY, 32'h0, 1'b0, 32'h0);
    send_command(ACT_SELL, 32'h0, 1'b0, 32'h0);
    drain_book();
    for (k = 0; k < SLOTS + 2; k++)
      send_command(ACT_REMOVE, (k < 5) ? 32'(k) * 32'h5555_AAAA : 32'h100 + k,
                   1'b0, 32'h0);
    drain_book();

    // random order flow over a small id pool so removes and duplicates hit
    for (k = 0; k < 110; k++) begin
      id = ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 40));
      pr = ($urandom_range(0, 5) == 0) ? $urandom()
                                       : 32'hFFFF_FF00 + $urandom_range(0, 6);
      if ($urandom_range(0, 1)) pr = ~pr;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_command(ACT_ADD, id, 1'($urandom_range(0, 1)), pr);
        4, 5:       send_command(ACT_REMOVE, id, 1'($urandom_range(0, 1)), $urandom());
        6, 7:       send_command(ACT_BUY, $urandom(), 1'($urandom_range(0, 1)), $urandom());
        default:    send_command(ACT_SELL, $urandom(), 1'($urandom_range(0, 1)), $urandom());
      endcase
      if (k == 55) drain_book();
    end
    drain_book();

    $display("Sent %0d commands, checked %0d result transactions.", n_sent, n_results);
    if (errors == 0) $display("limit_order_book test passed");
    else $display("limit_order_book test failed");
    $finish;
  end
endmodule
